### rtl/mlfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_pkg
// Types and command codes shared by the linear fade engine.
// ----------------------------------------------------------------------------
package mlfe_pkg;

  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_UWRITE  = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int  PROD_W     = 24;
  localparam logic [4:0] DIV_STEPS = 5'd24;
  localparam logic [15:0] ELAPSED_TOP = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [10:0] address;
    logic [7:0]  level;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] out_address;
    logic [7:0]  out_level;
    logic        running;
    logic        table_full;
    logic        last;
  } out_item_t;

endpackage

### rtl/mlfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/multichannel_linear_fade_engine_top.sv
`timescale 1ns / 1ps
// Every item ends with a scan of the channel table and a status result. A
// tick captures start levels from the store on its first tick after reset,
// clear or restart only, sends each moving channel through the
// one-bit-a-cycle shared divider, and sets a channel whose fade length has
// run out straight to its target.
// After reset a clearing pass zeroes the store; no
// item is taken meanwhile. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// multichannel_linear_fade_engine_top
// Channel table, universe byte store and sequenced linear crossfade.
// ----------------------------------------------------------------------------
module multichannel_linear_fade_engine_top #(
  parameter int MAX_CHANNELS   = 32,
  parameter int UNIVERSE_BYTES = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlfe_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlfe_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import mlfe_pkg::*;

  localparam int AW  = $clog2(UNIVERSE_BYTES);
  localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [11:0] UB   = 12'(UNIVERSE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(UNIVERSE_BYTES - 1);
  localparam logic [5:0] CMAX = 6'(MAX_CHANNELS);

  typedef enum logic [13:0] {
    S_CLR    = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_LDRD   = 14'b00000000000100,
    S_LDWR   = 14'b00000000001000,
    S_CAPRD  = 14'b00000000010000,
    S_CAPWR  = 14'b00000000100000,
    S_INC    = 14'b00000001000000,
    S_CHAN   = 14'b00000010000000,
    S_DIV    = 14'b00000100000000,
    S_DIVEND = 14'b00001000000000,
    S_WR     = 14'b00010000000000,
    S_WWAIT  = 14'b00100000000000,
    S_SCAN   = 14'b01000000000000,
    S_SWAIT  = 14'b10000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [15:0] elapsed_r, elapsed_nxt, fade_r, fade_nxt;
  logic [10:0] addr_r, addr_nxt;
  logic [7:0]  lvl_r, lvl_nxt, v_r, v_nxt;
  logic        full_r, full_nxt, run_r, run_nxt, dir_r, dir_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   out_r, out_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  bcnt_r, bcnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [10:0] chan_addr [MAX_CHANNELS];
  logic [7:0]  chan_start [MAX_CHANNELS];
  logic [7:0]  chan_cur [MAX_CHANNELS];
  logic [7:0]  chan_tgt [MAX_CHANNELS];

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_q, rd_val;
  logic          rd_oob_r, rd_oob_nxt;
  logic [10:0]   rd_addr;

  logic          ld_we, cap_we, cur_we;
  logic [CIW-1:0] ci;
  logic [7:0]    mag;
  logic [16:0]   trial;
  logic          in_acc;

  mlfe_ram #(.WIDTH(8), .DEPTH(UNIVERSE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign ci       = idx_r[CIW-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign rd_val    = rd_oob_r ? 8'd0 : ram_q;
  assign ram_raddr = rd_addr[AW-1:0];
  assign mag   = (chan_tgt[ci] >= chan_start[ci]) ? (chan_tgt[ci] - chan_start[ci])
                                                  : (chan_start[ci] - chan_tgt[ci]);
  assign trial = {rem_r[15:0], prod_r[PROD_W-1]};

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    elapsed_nxt = elapsed_r; fade_nxt = fade_r;
    addr_nxt = addr_r; lvl_nxt = lvl_r; v_nxt = v_r;
    full_nxt = full_r; run_nxt = run_r; dir_nxt = dir_r;
    ov_nxt = ov_r; out_nxt = out_r; prod_nxt = prod_r;
    rem_nxt = rem_r; bcnt_nxt = bcnt_r; clr_nxt = clr_r;
    ram_we = 1'b0; ram_waddr = clr_r; ram_wdata = 8'd0;
    rd_addr = addr_r;
    ld_we = 1'b0; cap_we = 1'b0; cur_we = 1'b0;

    if (cfg_we) fade_nxt = cfg_wdata;

    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_data.address; lvl_nxt = in_data.level;
          full_nxt = 1'b0; run_nxt = 1'b0; idx_nxt = '0;
          state_nxt = S_SCAN;
          case (in_data.cmd)
            CMD_LOAD: begin
              if (cnt_r >= CMAX) full_nxt = 1'b1;
              else state_nxt = S_LDRD;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0; elapsed_nxt = '0;
            end
            CMD_UWRITE: begin
              if ({1'b0, in_data.address} < UB) begin
                ram_we = 1'b1;
                ram_waddr = in_data.address[AW-1:0];
                ram_wdata = in_data.level;
              end
            end
            CMD_TICK: state_nxt = (elapsed_r == '0) ? S_CAPRD : S_INC;
            CMD_RESTART: elapsed_nxt = '0;
            default: ;
          endcase
        end
      end
      S_LDRD: begin
        rd_addr = addr_r;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        ld_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_CAPRD: begin
        rd_addr = chan_addr[ci];
        if (idx_r == cnt_r) state_nxt = S_INC;
        else state_nxt = S_CAPWR;
      end
      S_CAPWR: begin
        cap_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_CAPRD;
      end
      S_INC: begin
        if (elapsed_r != ELAPSED_TOP) elapsed_nxt = elapsed_r + 1'b1;
        idx_nxt = '0;
        state_nxt = S_CHAN;
      end
      S_CHAN: begin
        if (idx_r == cnt_r) begin
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end else if (chan_cur[ci] == chan_tgt[ci]) begin
          idx_nxt = idx_r + 1'b1;
        end else if (elapsed_r >= fade_r) begin
          v_nxt = chan_tgt[ci];
          state_nxt = S_WR;
        end else begin
          prod_nxt = PROD_W'(mag) * PROD_W'(elapsed_r);
          dir_nxt = (chan_tgt[ci] >= chan_start[ci]);
          rem_nxt = '0;
          bcnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        if (trial >= {1'b0, fade_r}) begin
          rem_nxt = trial - {1'b0, fade_r};
          prod_nxt = {prod_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          prod_nxt = {prod_r[PROD_W-2:0], 1'b0};
        end
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == DIV_STEPS - 5'd1) state_nxt = S_DIVEND;
      end
      S_DIVEND: begin
        v_nxt = dir_r ? (chan_start[ci] + prod_r[7:0]) : (chan_start[ci] - prod_r[7:0]);
        state_nxt = S_WR;
      end
      S_WR: begin
        cur_we = 1'b1;
        if ({1'b0, chan_addr[ci]} < UB) begin
          ram_we = 1'b1;
          ram_waddr = chan_addr[ci][AW-1:0];
          ram_wdata = v_r;
        end
        ov_nxt = 1'b1;
        out_nxt = '{kind: KIND_WRITE, out_address: chan_addr[ci], out_level: v_r,
                    running: 1'b0, table_full: 1'b0, last: 1'b0};
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_CHAN;
        end
      end
      S_SCAN: begin
        if (idx_r == cnt_r) begin
          ov_nxt = 1'b1;
          out_nxt = '{kind: KIND_STATUS, out_address: 11'd0, out_level: 8'd0,
                      running: run_r, table_full: full_r, last: 1'b1};
          state_nxt = S_SWAIT;
        end else begin
          if (chan_cur[ci] != chan_tgt[ci]) run_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SWAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    rd_oob_nxt = !({1'b0, rd_addr} < UB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; cnt_r <= '0; elapsed_r <= '0; fade_r <= '0;
      ov_r <= 1'b0; clr_r <= '0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; elapsed_r <= elapsed_nxt;
      fade_r <= fade_nxt; ov_r <= ov_nxt; clr_r <= clr_nxt; idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; lvl_r <= lvl_nxt; v_r <= v_nxt;
    full_r <= full_nxt; run_r <= run_nxt; dir_r <= dir_nxt; out_r <= out_nxt;
    prod_r <= prod_nxt; rem_r <= rem_nxt; bcnt_r <= bcnt_nxt; rd_oob_r <= rd_oob_nxt;
    if (ld_we) begin
      chan_addr[cnt_r[CIW-1:0]]  <= addr_r;
      chan_tgt[cnt_r[CIW-1:0]]   <= lvl_r;
      chan_start[cnt_r[CIW-1:0]] <= rd_val;
      chan_cur[cnt_r[CIW-1:0]]   <= rd_val;
    end
    if (cap_we) begin
      chan_start[ci] <= rd_val;
      chan_cur[ci]   <= rd_val;
    end
    if (cur_we) chan_cur[ci] <= v_r;
  end

endmodule

### tb/mlfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_checker
// Watches the fade engine's channels, predicts every result from the accepted
// items and the fade length register, and compares each result in order.
// ----------------------------------------------------------------------------
module mlfe_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mlfe_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mlfe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);
  import mlfe_pkg::*;

  localparam int NCH = 32;
  localparam int NBYTES = 2048;

  logic [10:0] ch_addr [NCH];
  logic [7:0]  ch_start [NCH];
  logic [7:0]  ch_cur [NCH];
  logic [7:0]  ch_tgt [NCH];
  int unsigned ch_used;
  logic [15:0] fade_len;
  logic [15:0] ticks_done;
  logic [7:0]  dmx_store [NBYTES];
  out_item_t   levels_due [$];

  function automatic logic [7:0] store_rd(logic [10:0] a);
    return (a < NBYTES) ? dmx_store[a] : 8'd0;
  endfunction

  task automatic push_write(logic [10:0] a, logic [7:0] v);
    out_item_t r;
    r = '0;
    r.kind = KIND_WRITE;
    r.out_address = a;
    r.out_level = v;
    levels_due.push_back(r);
  endtask

  task automatic predict_fade(in_item_t it);
    out_item_t st;
    logic [7:0] v;
    int unsigned mag;
    logic run;
    st = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (ch_used < NCH) begin
          ch_addr[ch_used] = it.address;
          ch_tgt[ch_used] = it.level;
          ch_start[ch_used] = store_rd(it.address);
          ch_cur[ch_used] = ch_start[ch_used];
          ch_used++;
        end else begin
          st.table_full = 1'b1;
        end
      end
      CMD_CLEAR: begin
        ch_used = 0;
        ticks_done = '0;
      end
      CMD_UWRITE: begin
        if (it.address < NBYTES) dmx_store[it.address] = it.level;
      end
      CMD_TICK: begin
        if (ticks_done == 0) begin
          for (int i = 0; i < ch_used; i++) begin
            ch_start[i] = store_rd(ch_addr[i]);
            ch_cur[i] = ch_start[i];
          end
        end
        if (ticks_done != ELAPSED_TOP) ticks_done++;
        for (int i = 0; i < ch_used; i++) begin
          if (ch_cur[i] != ch_tgt[i]) begin
            if (ticks_done >= fade_len) begin
              v = ch_tgt[i];
            end else if (ch_tgt[i] >= ch_start[i]) begin
              mag = ch_tgt[i] - ch_start[i];
              v = ch_start[i] + 8'((mag * ticks_done) / fade_len);
            end else begin
              mag = ch_start[i] - ch_tgt[i];
              v = ch_start[i] - 8'((mag * ticks_done) / fade_len);
            end
            ch_cur[i] = v;
            if (ch_addr[i] < NBYTES) dmx_store[ch_addr[i]] = v;
            push_write(ch_addr[i], v);
          end
        end
      end
      CMD_RESTART: ticks_done = '0;
      default: ;
    endcase
    run = 1'b0;
    for (int i = 0; i < ch_used; i++)
      if (ch_cur[i] != ch_tgt[i]) run = 1'b1;
    st.kind = KIND_STATUS;
    st.running = run;
    st.last = 1'b1;
    levels_due.push_back(st);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ch_used = 0;
      fade_len = '0;
      ticks_done = '0;
      foreach (dmx_store[i]) dmx_store[i] = 8'd0;
      levels_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) fade_len = cfg_wdata;
      if (in_valid && !in_stall) predict_fade(in_data);
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = levels_due.pop_front();
          if (want !== out_data) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
    pending = levels_due.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives fade scenes through the engine: directed corner items, then random
// phases of loads, store writes, ticks and restarts under several fade lengths.
// ----------------------------------------------------------------------------
module tb;
  import mlfe_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int        errors;
  int        pending;
  int        sent = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  always #1 clk = ~clk;

  multichannel_linear_fade_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mlfe_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // receiver side: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(logic [2:0] c, logic [10:0] a, logic [7:0] l);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data <= '{cmd: c, address: a, level: l};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_fade(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] rnd_addr();
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [7:0] rnd_lvl();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned fl, nch, nt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: jump fade with extreme addresses and levels
    send(CMD_UWRITE, 11'd0, 8'hFF);
    send(CMD_UWRITE, 11'h7FF, 8'h55);
    send(CMD_TICK, 11'd0, 8'd0);
    send(CMD_LOAD, 11'h7FF, 8'h00);
    send(CMD_LOAD, 11'd0, 8'hFF);
    send(CMD_LOAD, 11'h555, 8'hAA);
    send(CMD_LOAD, 11'h2AA, 8'h00);
    send(CMD_TICK, 11'd0, 8'd0);
    send(CMD_TICK, 11'h7FF, 8'hFF);
    send(3'd5, 11'h7FF, 8'hFF);
    send(3'd6, 11'd0, 8'd0);
    send(3'd7, 11'h3FF, 8'h0F);
    send(CMD_RESTART, 11'd0, 8'd0);
    send(CMD_UWRITE, 11'h555, 8'h00);
    send(CMD_TICK, 11'd0, 8'd0);
    send(CMD_CLEAR, 11'd0, 8'd0);
    send(CMD_TICK, 11'd0, 8'd0);

    set_fade(16'hFFFF);
    send(CMD_LOAD, 11'd9, 8'hFF);
    send(CMD_LOAD, 11'h7FF, 8'h80);
    repeat (4) send(CMD_TICK, 11'd0, 8'd0);
    send(CMD_CLEAR, 11'd0, 8'd0);

    // random fade scenes
    for (int ph = 0; sent < 365; ph++) begin
      if (sent > 300) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: fl = 0;
        1: fl = 1;
        2: fl = 16'hFFFF;
        default: fl = $urandom_range(2, 12);
      endcase
      set_fade(16'(fl));
      nch = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
      if (ph == 2) begin
        nch = 36;
        hold_req = 1'b1;
      end
      send(CMD_CLEAR, rnd_addr(), rnd_lvl());
      repeat ($urandom_range(0, 4)) send(CMD_UWRITE, rnd_addr(), rnd_lvl());
      repeat (nch) send(CMD_LOAD, rnd_addr(), rnd_lvl());
      nt = (fl > 12) ? $urandom_range(2, 5) : fl + $urandom_range(1, 3);
      if (nch > 20) nt = (nt > 4) ? 4 : nt;
      for (int t = 0; t < nt; t++) begin
        case ($urandom_range(0, 9))
          0: send(CMD_RESTART, rnd_addr(), rnd_lvl());
          1: send(CMD_UWRITE, rnd_addr(), rnd_lvl());
          2: send(3'($urandom_range(0, 7)), rnd_addr(), rnd_lvl());
          default: ;
        endcase
        send(CMD_TICK, rnd_addr(), rnd_lvl());
      end
      if (ph % 3 == 1) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
